[hdl/knn_pkg.sv]
package knn_pkg;
  localparam int MaxPoints = 1024;
  localparam int MaxDims = 16;
  localparam int MaxK = 16;
  localparam int PcW = 11;
  localparam int DcW = 5;
  localparam int KW = 5;
  localparam int PiW = 10;
  localparam int DiW = 4;
  localparam int FvW = 16;
  localparam int EpW = 14;
  localparam int StW = 2;

  localparam logic [StW-1:0] StatusOk = 2'd0;
  localparam logic [StW-1:0] StatusKBig = 2'd1;
  localparam logic [StW-1:0] StatusRange = 2'd2;

  localparam logic [1:0] RegPoints = 2'd0;
  localparam logic [1:0] RegDims = 2'd1;
  localparam logic [1:0] RegK = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_write;   // write feature store from input
    logic start;        // capture query, clear candidate list
    logic read_issue;   // issue store reads for (cur point, cur dim)
    logic acc_clear;    // start a new distance sum
    logic acc_add;      // add registered square
    logic mul_en;       // register product
    logic insert;       // offer finished distance to the list
    logic next_dim;     // advance dimension counter
    logic next_point;   // advance point counter
    logic sort_step;    // one pass of odd-even sort
    logic emit_load;    // load output register
    logic emit_err;     // output is an error result
  } knn_cmd_t;

  typedef struct packed {
    logic dim_last;
    logic point_last;
    logic point_self;
    logic emit_last;
    logic out_busy;
  } knn_stat_t;
endpackage

[hdl/knn_graph_builder.sv]
// k-nearest-neighbour search over a stored point set. mode 0 items load one
// Q8.8 feature and give no result; mode 1 items return the k nearest other
// points in ascending index order, or one error result. The input is not
// ready again until a query's last result has been loaded: the single
// multiply-accumulate unit reads, multiplies and accumulates every dimension
// of every other point and then inserts its distance into the candidate
// list, skipping the query point itself; the sort takes MAX_K+1 steps and
// results are loaded one at a time, each held back while the previous one
// waits on out_ready. An error result is loaded without a search or sort.
module knn_graph_builder import knn_pkg::*; #(
  parameter int MAX_POINTS = MaxPoints,
  parameter int MAX_DIMS = MaxDims,
  parameter int MAX_K = MaxK
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic mode,
  input  logic [PiW-1:0] point_index,
  input  logic [DiW-1:0] dimension_index,
  input  logic signed [FvW-1:0] feature_value,
  output logic out_valid,
  input  logic out_ready,
  output logic [PiW-1:0] neighbour_index,
  output logic [EpW-1:0] edge_position,
  output logic [StW-1:0] status,
  output logic last,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [PcW-1:0] cfg_data
);
  logic [PcW-1:0] point_count, pc;
  logic [DcW-1:0] dimension_count, dims;
  logic [KW-1:0] neighbour_count, k;
  logic qerr;
  logic [StW-1:0] err_status;
  // error code captured with the query
  logic [StW-1:0] status_hold;
  knn_cmd_t cmd;
  knn_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PcW'(2);
      dimension_count <= DcW'(1);
      neighbour_count <= KW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPoints: point_count <= cfg_data;
        RegDims: dimension_count <= cfg_data[DcW-1:0];
        RegK: neighbour_count <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  assign pc = (int'(point_count) > MAX_POINTS) ? PcW'(MAX_POINTS) : point_count;
  assign dims = (dimension_count == '0) ? DcW'(1) :
    (int'(dimension_count) > MAX_DIMS) ? DcW'(MAX_DIMS) : dimension_count;
  assign k = (neighbour_count == '0) ? KW'(1) :
    (int'(neighbour_count) > MAX_K) ? KW'(MAX_K) : neighbour_count;
  assign err_status = (PcW'(k) >= pc) ? StatusKBig : StatusRange;
  assign qerr = (PcW'(k) >= pc) || (PcW'(point_index) >= pc);

  knn_ctrl #(.MAX_K(MAX_K)) u_ctrl (
    .clk, .rst, .in_valid(valid), .in_ready(ready), .mode,
    .query_err(qerr), .stat, .cmd
  );

  knn_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS), .MAX_K(MAX_K)) u_dp (
    .clk, .rst, .cmd, .stat, .point_index, .dimension_index, .feature_value,
    .pc, .dims, .k, .err_status(status_hold), .neighbour_index, .edge_position,
    .status, .last, .out_valid, .out_ready
  );

  always_ff @(posedge clk) if (cmd.start) status_hold <= err_status;
endmodule

[hdl/knn_datapath.sv]
module knn_datapath import knn_pkg::*; #(
  parameter int MAX_POINTS = MaxPoints,
  parameter int MAX_DIMS = MaxDims,
  parameter int MAX_K = MaxK
) (
  input  logic clk,
  input  logic rst,
  input  knn_cmd_t cmd,
  output knn_stat_t stat,
  input  logic [PiW-1:0] point_index,
  input  logic [DiW-1:0] dimension_index,
  input  logic signed [FvW-1:0] feature_value,
  input  logic [PcW-1:0] pc,
  input  logic [DcW-1:0] dims,
  input  logic [KW-1:0] k,
  input  logic [StW-1:0] err_status,
  output logic [PiW-1:0] neighbour_index,
  output logic [EpW-1:0] edge_position,
  output logic [StW-1:0] status,
  output logic last,
  output logic out_valid,
  input  logic out_ready
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW = PW + DW;
  localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int SqW = 2 * (FvW + 1);
  localparam int DistW = SqW + DW + 1;

  logic signed [FvW-1:0] mem [2**AW];
  logic signed [FvW-1:0] rd_a, rd_b;
  logic [PW-1:0] qpt, cur;
  logic [DW:0] dcnt;
  logic [SqW-1:0] sq;
  logic [DistW-1:0] acc;
  logic [DistW-1:0] cand_dist [MAX_K];
  logic [PW-1:0] idx [MAX_K];
  logic [KIW:0] fill;
  logic [KIW:0] ecnt;
  logic sort_phase;
  logic [FvW:0] diff;

  function automatic logic [AW-1:0] addr(input logic [PW-1:0] p, input logic [DW:0] d);
    return {p, d[DW-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_write && int'(point_index) < MAX_POINTS &&
        int'(dimension_index) < MAX_DIMS)
      mem[addr(PW'(point_index), (DW+1)'(dimension_index))] <= feature_value;
    if (cmd.read_issue) begin
      rd_a <= mem[addr(qpt, dcnt)];
      rd_b <= mem[addr(cur, dcnt)];
    end
  end

  assign diff = {rd_a[FvW-1], rd_a} - {rd_b[FvW-1], rd_b};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) sq <= SqW'($signed(diff) * $signed(diff));
    if (cmd.acc_clear) acc <= '0;
    else if (cmd.acc_add) acc <= acc + DistW'(sq);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qpt <= PW'(point_index);
      cur <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.next_dim) dcnt <= dcnt + 1'b1;
      if (cmd.next_point) begin
        cur <= cur + 1'b1;
        dcnt <= '0;
      end
    end
  end

  assign stat.dim_last = (dcnt + 1'b1) == (DW+1)'(dims);
  assign stat.point_last = ({1'b0, cur} + 1'b1) == (PW+1)'(pc);
  assign stat.point_self = (cur == qpt);

  // candidate list: worst entry found by a balanced compare tree,
  // larger distance loses, later index loses among equal distances
  localparam int KP = 2 ** KIW;
  logic [KIW-1:0] worst;
  logic tv [1:2*KP-1];
  logic [DistW-1:0] td [1:2*KP-1];
  logic [PW-1:0] ti [1:2*KP-1];
  logic [KIW-1:0] tw [1:2*KP-1];
  always_comb begin
    for (int nd = 1; nd < 2*KP; nd++) begin
      tv[nd] = 1'b0;
      td[nd] = '0;
      ti[nd] = '0;
      tw[nd] = '0;
    end
    for (int i = 0; i < MAX_K; i++) begin
      tv[KP+i] = (i < int'(k));
      td[KP+i] = cand_dist[i];
      ti[KP+i] = idx[i];
      tw[KP+i] = KIW'(i);
    end
    for (int nd = KP-1; nd >= 1; nd--) begin
      if (!tv[2*nd+1] || (tv[2*nd] && (td[2*nd] > td[2*nd+1] ||
          (td[2*nd] == td[2*nd+1] && ti[2*nd] > ti[2*nd+1])))) begin
        tv[nd] = tv[2*nd];
        td[nd] = td[2*nd];
        ti[nd] = ti[2*nd];
        tw[nd] = tw[2*nd];
      end else begin
        tv[nd] = tv[2*nd+1];
        td[nd] = td[2*nd+1];
        ti[nd] = ti[2*nd+1];
        tw[nd] = tw[2*nd+1];
      end
    end
    worst = tw[1];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      fill <= '0;
      sort_phase <= 1'b0;
    end else if (cmd.insert) begin
      if (fill < (KIW+1)'(k)) begin
        cand_dist[fill[KIW-1:0]] <= acc;
        idx[fill[KIW-1:0]] <= cur;
        fill <= fill + 1'b1;
      end else if (acc < cand_dist[worst]) begin
        cand_dist[worst] <= acc;
        idx[worst] <= cur;
      end
    end else if (cmd.sort_step) begin
      sort_phase <= ~sort_phase;
      for (int i = 0; i + 1 < MAX_K; i++) begin
        if ((i % 2) == int'(sort_phase) && (i + 1) < k && idx[i] > idx[i+1]) begin
          idx[i] <= idx[i+1];
          idx[i+1] <= idx[i];
        end
      end
    end
  end

  // output register
  logic [EpW-1:0] base;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ecnt <= '0;
    end else begin
      if (cmd.emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.start) begin
        ecnt <= '0;
        base <= EpW'(point_index) * EpW'(k);
      end
      if (cmd.emit_load) begin
        if (cmd.emit_err) begin
          neighbour_index <= '0;
          edge_position <= '0;
          status <= err_status;
          last <= 1'b1;
        end else begin
          neighbour_index <= PiW'(idx[ecnt[KIW-1:0]]);
          edge_position <= base + EpW'(ecnt);
          status <= StatusOk;
          last <= (ecnt + 1'b1) == (KIW+1)'(k);
          ecnt <= ecnt + 1'b1;
        end
      end
    end
  end
  assign stat.emit_last = (ecnt + 1'b1) == (KIW+1)'(k);
  assign stat.out_busy = out_valid && !out_ready;
endmodule

[hdl/knn_ctrl.sv]
module knn_ctrl import knn_pkg::*; #(
  parameter int MAX_K = MaxK
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic mode,
  input  logic query_err,
  input  knn_stat_t stat,
  output knn_cmd_t cmd
);
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SMul = 3'd2, SAcc = 3'd3,
    SIns = 3'd4, SSort = 3'd5, SEmit = 3'd6;
  logic [2:0] state, state_next;
  logic [6:0] scnt, scnt_next;
  logic err, err_next;

  assign in_ready = (state == SIdle);

  always_comb begin
    cmd = '0;
    state_next = state;
    scnt_next = scnt;
    err_next = err;
    unique case (state)
      SIdle: if (in_valid) begin
        if (!mode) cmd.load_write = 1'b1;
        else begin
          cmd.start = 1'b1;
          cmd.acc_clear = 1'b1;
          err_next = query_err;
          state_next = query_err ? SEmit : SRead;
        end
      end
      SRead: begin
        if (stat.point_self) begin
          cmd.next_point = 1'b1;
          if (stat.point_last) begin
            state_next = SSort;
            scnt_next = '0;
          end
        end else begin
          cmd.read_issue = 1'b1;
          state_next = SMul;
        end
      end
      SMul: begin
        cmd.mul_en = 1'b1;
        state_next = SAcc;
      end
      SAcc: begin
        cmd.acc_add = 1'b1;
        if (stat.dim_last) state_next = SIns;
        else begin
          cmd.next_dim = 1'b1;
          state_next = SRead;
        end
      end
      SIns: begin
        cmd.insert = 1'b1;
        cmd.acc_clear = 1'b1;
        cmd.next_point = 1'b1;
        if (stat.point_last) begin
          state_next = SSort;
          scnt_next = '0;
        end else state_next = SRead;
      end
      SSort: begin
        cmd.sort_step = 1'b1;
        scnt_next = scnt + 1'b1;
        if (scnt == 7'(MAX_K)) state_next = SEmit;
      end
      SEmit: if (!stat.out_busy) begin
        cmd.emit_load = 1'b1;
        cmd.emit_err = err;
        if (err || stat.emit_last) state_next = SIdle;
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      scnt <= '0;
      err <= 1'b0;
    end else begin
      state <= state_next;
      scnt <= scnt_next;
      err <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_write |-> state == SIdle) else $error("load outside idle");
  a_emit_after_sort: assert property (@(posedge clk) disable iff (rst)
    (state == SSort && state_next == SEmit) |-> !err) else $error("sort on error");
  a_ins_once: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> !cmd.insert) else $error("double insert");
`endif
endmodule
